@@ src/fsqrt_pkg.sv @@
// Package for the single-precision square root block.
// Shared constants and the control struct between sequencer and datapath.
`default_nettype none
package fsqrt_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned RootW = 25;
  localparam int unsigned RemW = 27;
  localparam int unsigned CntW = 5;
  localparam logic [7:0] ExpAllOnes = 8'hFF;
  localparam logic [31:0] ExpFieldMask = 32'h7F80_0000;

  typedef struct packed {
    logic load;
    logic step;
  } fsqrt_ctrl_t;
endpackage
`default_nettype wire

@@ src/float32_square_root.sv @@
// Top level: IEEE-754 single square root with round to nearest even.
// Depends on fsqrt_pkg and fsqrt_core.
//
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, operand  | request in
//  out     | out_valid_o, out_stall_i, root   | request out
//
// A regular request goes through accept, load, 25 recurrence steps and round.
// Special operands (NaN, inf, zero, negative) are resolved in the accept state.
// Subnormals are first normalized by a left-shift search in the StNorm state.
// Reset clears the sequencer; the result register holds while stalled.
`default_nettype none
module float32_square_root import fsqrt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] operand_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      root_bits_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNorm = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StRnd  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [23:0] man_q, man_d;
  logic signed [9:0] exp_q, exp_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] res_q, res_d;
  fsqrt_ctrl_t ctrl;
  logic [49:0] radicand;
  logic [RootW-1:0] root;
  logic sticky;
  logic accept, out_free;
  logic [7:0] ef;
  logic [22:0] fr;
  logic signed [9:0] exp_h;
  logic [23:0] sig;
  logic [24:0] sig_r;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign accept = in_valid_i && !in_stall_o;
  assign ef = operand_bits_i[30:23];
  assign fr = operand_bits_i[22:0];

  assign radicand = exp_q[0] ? {man_q, 26'b0} : {1'b0, man_q, 25'b0};
  assign exp_h = exp_q >>> 1;
  assign sig = root[24:1];
  assign sig_r = {1'b0, sig} + {24'b0, root[0] & (sticky | sig[0])};

  fsqrt_core u_core (
    .clk_i, .ctrl_i(ctrl), .radicand_i(radicand),
    .root_o(root), .sticky_o(sticky)
  );

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    man_d = man_q;
    exp_d = exp_q;
    res_d = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (ef == ExpAllOnes) begin
            res_d = (fr != '0 || !operand_bits_i[31]) ? operand_bits_i : '0;
            out_valid_d = 1'b1;
          end else if (operand_bits_i[31] || (ef == '0 && fr == '0)) begin
            res_d = '0;
            out_valid_d = 1'b1;
          end else if (ef == '0) begin
            man_d = {1'b0, fr};
            exp_d = -10'sd126;
            state_d = StNorm;
          end else begin
            man_d = {1'b1, fr};
            exp_d = 10'(signed'({2'b0, ef})) - 10'sd127;
            state_d = StLoad;
          end
        end
      end
      StNorm: begin
        if (man_q[23]) begin
          state_d = StLoad;
        end else begin
          man_d = {man_q[22:0], 1'b0};
          exp_d = exp_q - 10'sd1;
        end
      end
      StLoad: begin
        ctrl.load = 1'b1;
        cnt_d = CntW'(RootW - 1);
        state_d = StRun;
      end
      StRun: begin
        ctrl.step = 1'b1;
        if (cnt_q == '0) state_d = StRnd;
        else cnt_d = cnt_q - 1'b1;
      end
      StRnd: begin
        if (out_free) begin
          if (sig_r[24]) begin
            res_d = {1'b0, 8'(exp_h + 10'sd128), 23'b0};
          end else begin
            res_d = {1'b0, 8'(exp_h + 10'sd127), sig_r[22:0]};
          end
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    man_q <= man_d;
    exp_q <= exp_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign root_bits_o = res_q;

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && cnt_q == '0) |=> state_q == StRnd) else $error("run overrun");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(res_q)) else $error("result lost");
  a_norm_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoad) |-> man_q[23]) else $error("not normalized");
endmodule
`default_nettype wire

@@ src/fsqrt_core.sv @@
// Digit-recurrence root unit: one root bit per step.
// Depends on fsqrt_pkg.
`default_nettype none
module fsqrt_core import fsqrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire fsqrt_ctrl_t       ctrl_i,
  input  wire logic [49:0]       radicand_i,
  output logic [RootW-1:0]       root_o,
  output logic                   sticky_o
);
  logic [49:0]      rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0]  shifted, trial;

  always_comb begin
    shifted = {rem_q[RemW-3:0], rad_q[49:48]};
    trial   = {root_q, 2'b01};
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    if (ctrl_i.load) begin
      rad_d = radicand_i;
      rem_d = '0;
      root_d = '0;
    end else if (ctrl_i.step) begin
      rad_d = {rad_q[47:0], 2'b00};
      if (shifted >= trial) begin
        rem_d = shifted - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign sticky_o = (rem_q != '0);
endmodule
`default_nettype wire

@@ tb/float32_square_root_tb.sv @@
// Testbench for float32_square_root: directed table, then random operands.
// Checks each root against the table value or a bit-exact round-to-nearest-even predictor.
// Depends on fsqrt_pkg and the float32_square_root RTL.
`default_nettype none
module float32_square_root_tb import fsqrt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 80;

  typedef struct {
    logic [31:0] operand;
    logic [31:0] root;
    bit known;
  } sqrt_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [31:0] operand_bits_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [31:0] root_bits_o;

  logic [31:0] root_queue[$];
  int unsigned mismatch_count;
  int unsigned root_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit sending_done;

  float32_square_root DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operand_bits_i(operand_bits_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .root_bits_o(root_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] predict_root(logic [31:0] x);
    logic [7:0] efield;
    logic [22:0] frac;
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] trial;
    logic [31:0] sig;
    int e;
    efield = x[30:23];
    frac = x[22:0];
    if (efield == ExpAllOnes) begin
      if (frac != 0) return x;
      return x[31] ? 32'h0 : x;
    end
    if (x[31] || x[30:0] == 0) return 32'h0;
    if (efield == 0) begin
      m = {41'h0, frac};
      e = -126;
      while (m < 64'h80_0000) begin
        m = m << 1;
        e--;
      end
    end else begin
      m = {40'h0, 1'b1, frac};
      e = int'(efield) - 127;
    end
    if (e % 2 != 0) begin
      m = m << 1;
      e = e - 1;
    end
    v = m << 25;
    rem = 0;
    q = 0;
    for (int i = 24; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (q << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        q = (q << 1) | 64'd1;
      end else begin
        q = q << 1;
      end
    end
    sig = q[32:1];
    e = e / 2;
    if (q[0] && (rem != 0 || sig[0])) sig = sig + 1;
    if (sig >= 32'h100_0000) begin
      sig = sig >> 1;
      e++;
    end
    return {1'b0, 8'(e + 127), sig[22:0]};
  endfunction

  task automatic send_request(logic [31:0] operand, logic [31:0] root, bit known);
    logic [31:0] want;
    want = known ? root : predict_root(operand);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      operand_bits_i <= $urandom();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operand_bits_i <= operand;
    root_queue.push_back(want);
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: r[30:23] = 8'h00;
      1: r[30:23] = ExpAllOnes;
      2: r[30:0] = {8'h00, 23'(1) << $urandom_range(22)};
      3: r[31] = 1'b1;
      default: r[31] = 1'b0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_valid_o && !out_stall_i) begin
        root_count <= root_count + 1;
        if (root_queue.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("unexpected root %h", root_bits_o);
        end else begin
          if (root_bits_o !== root_queue[0]) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("root mismatch: expected %h actual %h", root_queue[0], root_bits_o);
          end
          void'(root_queue.pop_front());
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    sqrt_row_t rows[$];
    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'h0000_0000, 1'b1},
      '{32'h7F80_0000, 32'h7F80_0000, 1'b1},
      '{32'hFF80_0000, 32'h0000_0000, 1'b1},
      '{32'h7FC0_0000, 32'h7FC0_0000, 1'b1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      '{32'h7F80_0001, 32'h7F80_0001, 1'b1},
      '{32'hBF80_0000, 32'h0000_0000, 1'b1},
      '{32'h8000_0001, 32'h0000_0000, 1'b1},
      '{32'h3F80_0000, 32'h3F80_0000, 1'b1},
      '{32'h4080_0000, 32'h4000_0000, 1'b1},
      '{32'h4000_0000, 32'h0, 1'b0},
      '{32'h0000_0001, 32'h0, 1'b0},
      '{32'h0000_0002, 32'h0, 1'b0},
      '{32'h007F_FFFF, 32'h0, 1'b0},
      '{32'h0040_0000, 32'h0, 1'b0},
      '{32'h0080_0000, 32'h0, 1'b0},
      '{32'h7F7F_FFFF, 32'h0, 1'b0},
      '{32'h3F7F_FFFF, 32'h0, 1'b0},
      '{32'h3F80_0001, 32'h0, 1'b0},
      '{32'h5555_5555, 32'h0, 1'b0},
      '{32'h2AAA_AAAA, 32'h0, 1'b0}
    };
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operand_bits_i = 32'h0;
    out_stall_i = 1'b0;
    mismatch_count = 0;
    root_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sending_done = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (rows[i]) send_request(rows[i].operand, rows[i].root, rows[i].known);
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (90) send_request(random_operand(), 32'h0, 1'b0);
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (root_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0 && root_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
